// ----- hdl/tcp_flow_payload_capture_defines.svh -----
// Assertion helper macros shared by the capture block.
`ifndef TCP_FLOW_PAYLOAD_CAPTURE_DEFINES_SVH
`define TCP_FLOW_PAYLOAD_CAPTURE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TFPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define TFPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/tfpc_pkg.sv -----
// ---------------------------------------------------------------------------
// tfpc_pkg
// Constants and types for the TCP flow payload capture block.
// ---------------------------------------------------------------------------
package tfpc_pkg;
    localparam int TableEntries    = 5;
    localparam int PayloadBytes    = 100;
    localparam int LinkHeaderBytes = 14;
    localparam int SlotW           = 3;
    localparam int LenW            = 7;
    localparam int AddrW           = 9;   // holds TableEntries * PayloadBytes

    localparam logic [15:0] MatchPortReset  = 16'd15100;
    localparam logic [15:0] MinPayloadReset = 16'd10;
    localparam logic [7:0]  ProtoTcp        = 8'd6;

    localparam logic [0:0] RegMatchPort  = 1'd0;
    localparam logic [0:0] RegMinPayload = 1'd1;

    typedef enum logic [3:0] {
        V_TRUNC    = 4'd0,
        V_IP_SHORT = 4'd1,
        V_NOT_TCP  = 4'd2,
        V_PORT     = 4'd3,
        V_SHORT    = 4'd4,
        V_FULL     = 4'd5,
        V_APPEND   = 4'd6,
        V_NEW      = 4'd7,
        V_READ     = 4'd8
    } verdict_t;
endpackage

// ----- hdl/tcp_flow_payload_capture.sv -----
// ---------------------------------------------------------------------------
// tcp_flow_payload_capture
// Parses Ethernet/IPv4/TCP frames byte by byte and captures TCP payload
// into a small flow table; reads return stored payload bytes.
// ---------------------------------------------------------------------------
// Usage: the slave channel takes one word per cycle while s_tready is high:
// a frame byte (tuser 0) or a read request (tuser 1). A frame's final byte
// carries tlast and yields one result word with the verdict; a read always
// yields one result word. Other frame bytes yield nothing. Configuration
// writes (match port, minimum payload) go through cfg_wr_en/cfg_addr/cfg_data
// while the block is idle. Throughput: one word per cycle while s_tready is
// high. The input register holds each accepted word; stage 1 parses it and
// presents its read address to the payload RAM, whose registered output is
// loaded together with the result register and drives m_tdata beside it.
// Reset clears the parser, the table (valid bits, lengths and counts) and
// the configuration registers to their defaults; payload RAM is not cleared.
// When the master side stalls, the result register holds and s_tready drops
// only while both the result register and the stage behind it are full.
// ---------------------------------------------------------------------------
`include "tcp_flow_payload_capture_defines.svh"

module tcp_flow_payload_capture (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], read_slot[10:8], read_index[17:11]
    input  logic        s_tlast,
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // verdict, entry_slot, stored_length, frame_count,
                                   // read_data, read_hit (from the lowest bit up)
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_data
);
    localparam int NE = tfpc_pkg::TableEntries;
    localparam int PB = tfpc_pkg::PayloadBytes;
    localparam int LH = tfpc_pkg::LinkHeaderBytes;

    // Configuration registers.
    logic [15:0] match_port_reg, min_payload_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_port_reg  <= tfpc_pkg::MatchPortReset;
            min_payload_reg <= tfpc_pkg::MinPayloadReset;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                tfpc_pkg::RegMatchPort:  match_port_reg  <= cfg_data;
                tfpc_pkg::RegMinPayload: min_payload_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage flow: stage 1 (work) and stage 2 (result) with stall.
    logic s1_valid_reg, s2_valid_reg, s2_emit_reg;
    logic adv2, adv1;
    assign adv2     = !s2_valid_reg || m_tready;
    assign adv1     = adv2;
    assign s_tready = adv1 || !s1_valid_reg;

    logic        in_fire;
    assign in_fire = s_tvalid && s_tready;

    // Input register.
    logic        s1_kind_reg, s1_last_reg;
    logic [7:0]  s1_byte_reg;
    logic [2:0]  s1_rslot_reg;
    logic [6:0]  s1_ridx_reg;
    logic        s1_go;
    assign s1_go = s1_valid_reg && adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
        if (in_fire) begin
            s1_kind_reg  <= s_tuser;
            s1_last_reg  <= s_tlast;
            s1_byte_reg  <= s_tdata[7:0];
            s1_rslot_reg <= s_tdata[10:8];
            s1_ridx_reg  <= s_tdata[17:11];
        end
    end

    // Frame parser state.
    logic [15:0] pos_reg;
    logic [5:0]  iph_reg, tcph_reg;
    logic [15:0] tot_reg;
    logic [63:0] addr_reg, seq_reg;
    logic [31:0] ports_reg;
    logic [3:0]  status_reg;
    logic [2:0]  slot_reg;

    logic        valid_reg [NE];
    logic [63:0] eaddr_reg [NE];
    logic [31:0] eports_reg [NE];
    logic [63:0] eseq_reg [NE];
    logic [6:0]  elen_reg [NE];
    logic [15:0] ecnt_reg [NE];

    // Combinational parse of one frame byte.
    logic [15:0] pos_next, tot_next;
    logic [5:0]  iph_next, tcph_next;
    logic [63:0] addr_next, seq_next;
    logic [31:0] ports_next;
    logic [3:0]  status_next;
    logic [16:0] t_pos, dec_pos, dec_cur, pay_end;
    logic [5:0]  h_cur;
    logic        do_decide, do_store;
    logic [17:0] plen;
    logic [NE-1:0] hit_vec, free_vec;
    logic [2:0]  hit_idx, free_idx;
    logic        any_hit, any_free;
    logic [16:0] p17;
    logic [7:0]  b;

    always_comb begin
        b          = s1_byte_reg;
        p17        = {1'b0, pos_reg};
        pos_next   = pos_reg;
        iph_next   = iph_reg;
        tot_next   = tot_reg;
        addr_next  = addr_reg;
        ports_next = ports_reg;
        seq_next   = seq_reg;
        tcph_next  = tcph_reg;
        status_next = status_reg;
        do_decide  = 1'b0;
        do_store   = 1'b0;
        t_pos      = 17'(LH) + 17'(iph_reg);
        h_cur      = (tcph_reg > 6'd13) ? tcph_reg : 6'd13;
        dec_pos    = t_pos + 17'(h_cur) - 17'd1;
        dec_cur    = dec_pos;
        pay_end    = 17'(LH) + 17'(tot_reg);
        if (status_reg == tfpc_pkg::V_TRUNC) begin
            if (p17 == 17'(LH)) begin
                iph_next = {b[3:0], 2'b00};
                if (iph_next < 6'd20) status_next = tfpc_pkg::V_IP_SHORT;
            end else if (p17 == 17'(LH + 2) || p17 == 17'(LH + 3)) begin
                tot_next = {tot_reg[7:0], b};
            end else if (p17 == 17'(LH + 9)) begin
                if (b != tfpc_pkg::ProtoTcp) status_next = tfpc_pkg::V_NOT_TCP;
            end else if (p17 >= 17'(LH + 12) && p17 < 17'(LH + 20)) begin
                addr_next = {addr_reg[55:0], b};
            end
            if (status_next == tfpc_pkg::V_TRUNC && p17 > 17'(LH) && p17 >= t_pos) begin
                if (p17 < t_pos + 17'd4) begin
                    ports_next = {ports_reg[23:0], b};
                    if (p17 == t_pos + 17'd3 && ports_next[15:0] != match_port_reg)
                        status_next = tfpc_pkg::V_PORT;
                end else if (p17 < t_pos + 17'd12) begin
                    seq_next = {seq_reg[55:0], b};
                end else if (p17 == t_pos + 17'd12) begin
                    tcph_next = {b[7:4], 2'b00};
                end
                dec_cur = t_pos + 17'((tcph_next > 6'd13) ? tcph_next : 6'd13) - 17'd1;
                if (status_next == tfpc_pkg::V_TRUNC && p17 >= t_pos + 17'd12
                    && p17 == dec_cur)
                    do_decide = 1'b1;
            end
        end else if (status_reg == tfpc_pkg::V_APPEND || status_reg == tfpc_pkg::V_NEW) begin
            if (p17 > dec_pos && p17 < pay_end && elen_reg[slot_reg] < 7'(PB))
                do_store = 1'b1;
        end
        if (pos_reg != 16'hFFFF) pos_next = pos_reg + 16'd1;
    end

    // Decision: length check and table lookup in parallel.
    always_comb begin
        plen = 18'({2'b00, tot_reg}) - 18'(iph_next) - 18'(tcph_next);
        for (int i = 0; i < NE; i++) begin
            hit_vec[i]  = valid_reg[i] && eaddr_reg[i] == addr_next
                          && eports_reg[i] == ports_next && eseq_reg[i] == seq_next;
            free_vec[i] = !valid_reg[i];
        end
        any_hit = |hit_vec;
        any_free = |free_vec;
        hit_idx = '0;
        free_idx = '0;
        for (int i = NE - 1; i >= 0; i--) begin
            if (hit_vec[i])  hit_idx  = 3'(i);
            if (free_vec[i]) free_idx = 3'(i);
        end
    end

    logic [3:0] dec_status;
    always_comb begin
        if (plen[17] || plen[16:0] <= {1'b0, min_payload_reg})
            dec_status = tfpc_pkg::V_SHORT;
        else if (any_hit)
            dec_status = tfpc_pkg::V_APPEND;
        else if (any_free)
            dec_status = tfpc_pkg::V_NEW;
        else
            dec_status = tfpc_pkg::V_FULL;
    end

    logic frame_go, read_go;
    assign frame_go = s1_go && !s1_kind_reg;
    assign read_go  = s1_go && s1_kind_reg;

    // Final status and slot after this byte.
    logic [3:0]  fin_status;
    logic [2:0]  fin_slot;
    always_comb begin
        fin_status = do_decide ? dec_status : status_next;
        fin_slot   = slot_reg;
        if (do_decide && dec_status == tfpc_pkg::V_APPEND) fin_slot = hit_idx;
        if (do_decide && dec_status == tfpc_pkg::V_NEW)    fin_slot = free_idx;
    end

    // Parser and table update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0; iph_reg <= '0; tot_reg <= '0; addr_reg <= '0;
            ports_reg <= '0; seq_reg <= '0; tcph_reg <= '0;
            status_reg <= tfpc_pkg::V_TRUNC; slot_reg <= '0;
            for (int i = 0; i < NE; i++) begin
                valid_reg[i] <= 1'b0;
                elen_reg[i]  <= '0;
                ecnt_reg[i]  <= '0;
            end
        end else if (frame_go) begin
            if (s1_last_reg) begin
                pos_reg <= '0; iph_reg <= '0; tot_reg <= '0; addr_reg <= '0;
                ports_reg <= '0; seq_reg <= '0; tcph_reg <= '0;
                status_reg <= tfpc_pkg::V_TRUNC; slot_reg <= '0;
            end else begin
                pos_reg <= pos_next; iph_reg <= iph_next; tot_reg <= tot_next;
                addr_reg <= addr_next; ports_reg <= ports_next; seq_reg <= seq_next;
                tcph_reg <= tcph_next; status_reg <= fin_status; slot_reg <= fin_slot;
            end
            if (do_decide && dec_status == tfpc_pkg::V_APPEND) begin
                if (ecnt_reg[hit_idx] != 16'hFFFF)
                    ecnt_reg[hit_idx] <= ecnt_reg[hit_idx] + 16'd1;
            end
            if (do_decide && dec_status == tfpc_pkg::V_NEW) begin
                valid_reg[free_idx]  <= 1'b1;
                eaddr_reg[free_idx]  <= addr_next;
                eports_reg[free_idx] <= ports_next;
                eseq_reg[free_idx]   <= seq_next;
                elen_reg[free_idx]   <= '0;
                ecnt_reg[free_idx]   <= 16'd1;
            end
            if (do_store)
                elen_reg[slot_reg] <= elen_reg[slot_reg] + 7'd1;
        end
    end

    // Payload RAM: write on store, read at the requested byte. While a result
    // waits, the read address of that result is presented again.
    logic [tfpc_pkg::AddrW-1:0] wr_addr, rd_addr, rd_req_addr, rd_addr_reg;
    logic [7:0] ram_q;
    assign wr_addr = tfpc_pkg::AddrW'(slot_reg) * tfpc_pkg::AddrW'(PB)
                     + tfpc_pkg::AddrW'(elen_reg[slot_reg]);
    assign rd_req_addr = tfpc_pkg::AddrW'(s1_rslot_reg) * tfpc_pkg::AddrW'(PB)
                         + tfpc_pkg::AddrW'(s1_ridx_reg);
    assign rd_addr = s1_go ? rd_req_addr : rd_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_addr_reg <= '0;
        end else if (s1_go) begin
            rd_addr_reg <= rd_req_addr;
        end
    end

    tfpc_ram #(.WIDTH(8), .DEPTH(NE * PB)) u_ram (
        .aclk    (aclk),
        .wr_en   (frame_go && do_store),
        .wr_addr (wr_addr),
        .wr_data (s1_byte_reg),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Result fields computed at stage 1, RAM byte merged at stage 2.
    logic        r_ok, r_hit;
    logic [3:0]  o_verdict;
    logic [2:0]  o_slot;
    logic [6:0]  o_len, len_after;
    logic [15:0] o_cnt, cnt_after;
    always_comb begin
        r_ok = s1_rslot_reg < 3'(NE) && valid_reg[s1_rslot_reg];
        r_hit = r_ok && s1_ridx_reg < elen_reg[s1_rslot_reg] && s1_ridx_reg < 7'(PB);
        len_after = elen_reg[fin_slot];
        cnt_after = ecnt_reg[fin_slot];
        if (do_store) len_after = elen_reg[slot_reg] + 7'd1;
        if (do_decide && dec_status == tfpc_pkg::V_NEW) begin
            len_after = '0; cnt_after = 16'd1;
        end else if (do_decide && dec_status == tfpc_pkg::V_APPEND) begin
            cnt_after = (ecnt_reg[hit_idx] != 16'hFFFF) ? ecnt_reg[hit_idx] + 16'd1
                                                         : ecnt_reg[hit_idx];
        end
        o_verdict = '0; o_slot = '0; o_len = '0; o_cnt = '0;
        if (s1_kind_reg) begin
            o_verdict = tfpc_pkg::V_READ;
            o_slot = s1_rslot_reg;
            if (r_ok) begin
                o_len = elen_reg[s1_rslot_reg];
                o_cnt = ecnt_reg[s1_rslot_reg];
            end
        end else begin
            o_verdict = fin_status;
            if (fin_status == tfpc_pkg::V_APPEND || fin_status == tfpc_pkg::V_NEW) begin
                o_slot = fin_slot; o_len = len_after; o_cnt = cnt_after;
            end
        end
    end

    logic [29:0] s2_fields_reg;
    logic        s2_hit_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s2_emit_reg  <= 1'b0;
        end else if (adv2) begin
            s2_valid_reg <= s1_go && (s1_kind_reg || s1_last_reg);
            s2_emit_reg  <= s1_go && (s1_kind_reg || s1_last_reg);
        end
        if (adv2 && s1_go) begin
            s2_fields_reg <= {o_cnt, o_len, o_slot, o_verdict};
            s2_hit_reg    <= r_hit && s1_kind_reg;
        end
    end

    // The RAM output holds while stalled because its read address is held too.
    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {1'b0, s2_hit_reg, s2_hit_reg ? ram_q : 8'd0, s2_fields_reg};

    `TFPC_ASSERT_IMP(a_emit_matches_valid, 1'b1, s2_emit_reg == s2_valid_reg,
        "result valid out of step")
    `TFPC_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid,
        "result dropped while stalled")
    `TFPC_ASSERT_IMP(a_slot_range, m_tvalid && m_tdata[3:0] != tfpc_pkg::V_READ,
        m_tdata[6:4] < 3'(NE), "frame result slot out of range")
endmodule

// ----- hdl/tfpc_ram.sv -----
// ---------------------------------------------------------------------------
// tfpc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module tfpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- bench/tcp_flow_payload_capture_test.sv -----
// ---------------------------------------------------------------------------
// tcp_flow_payload_capture_test
// Drives Ethernet/IPv4/TCP frames and read requests into the capture block,
// predicts every result word from a behavioral copy of the parser and flow
// table, and checks each result field by field under random idling and stalls.
// ---------------------------------------------------------------------------
module tcp_flow_payload_capture_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Result word layout, lowest field in the lowest bits.
    typedef struct packed {
        logic       hit;
        logic [7:0] rdata;
        logic [15:0] count;
        logic [6:0] length;
        logic [2:0] slot;
        tfpc_pkg::verdict_t verdict;
    } result_t;

    typedef struct {
        logic [31:0] src, dst, seq, ack;
        logic [15:0] sport;
    } flow_key_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [15:0] cfg_data;

    tcp_flow_payload_capture DUT (.*);

    // Shadow copy of configuration, parser and table.
    logic [15:0] cap_port, cap_min_payload;
    logic [15:0] pos;
    logic [5:0]  ip_hdr_len, tcp_hdr_len;
    logic [15:0] ip_total;
    logic [63:0] cur_addrs, cur_seq_ack;
    logic [31:0] cur_ports;
    tfpc_pkg::verdict_t status;
    logic [2:0]  cur_slot;
    bit          tbl_valid[tfpc_pkg::TableEntries];
    logic [63:0] tbl_addrs[tfpc_pkg::TableEntries];
    logic [31:0] tbl_ports[tfpc_pkg::TableEntries];
    logic [63:0] tbl_seq_ack[tfpc_pkg::TableEntries];
    logic [6:0]  tbl_len[tfpc_pkg::TableEntries];
    logic [15:0] tbl_count[tfpc_pkg::TableEntries];
    logic [7:0]  tbl_bytes[tfpc_pkg::TableEntries][tfpc_pkg::PayloadBytes];

    result_t     pending_results[$];
    logic [7:0]  frame_bytes[$];
    flow_key_t   flows[8];
    int          stall_pct, gap_pct, read_mix_pct;
    int          hold_req;
    int          words_sent;
    bit          failed;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Frame parser and flow table predictor
    // ------------------------------------------------------------------
    function automatic void clear_frame();
        pos = 0; ip_hdr_len = 0; ip_total = 0; cur_addrs = 0;
        cur_ports = 0; cur_seq_ack = 0; tcp_hdr_len = 0;
        status = tfpc_pkg::V_TRUNC; cur_slot = 0;
    endfunction

    function automatic int decision_at();
        int h;
        h = (tcp_hdr_len > 13) ? tcp_hdr_len : 13;
        return tfpc_pkg::LinkHeaderBytes + ip_hdr_len + h - 1;
    endfunction

    // Capture decision once the TCP header is complete.
    function automatic void decide_capture();
        int plen;
        plen = int'(ip_total) - int'(ip_hdr_len) - int'(tcp_hdr_len);
        if (plen < 0 || plen <= int'(cap_min_payload)) begin
            status = tfpc_pkg::V_SHORT;
            return;
        end
        for (int i = 0; i < tfpc_pkg::TableEntries; i++) begin
            if (tbl_valid[i] && tbl_addrs[i] == cur_addrs && tbl_ports[i] == cur_ports
                    && tbl_seq_ack[i] == cur_seq_ack) begin
                status = tfpc_pkg::V_APPEND;
                cur_slot = 3'(i);
                if (tbl_count[i] != 16'hFFFF) tbl_count[i]++;
                return;
            end
        end
        for (int i = 0; i < tfpc_pkg::TableEntries; i++) begin
            if (!tbl_valid[i]) begin
                tbl_valid[i] = 1'b1;
                tbl_addrs[i] = cur_addrs;
                tbl_ports[i] = cur_ports;
                tbl_seq_ack[i] = cur_seq_ack;
                tbl_len[i] = 0;
                tbl_count[i] = 1;
                status = tfpc_pkg::V_NEW;
                cur_slot = 3'(i);
                return;
            end
        end
        status = tfpc_pkg::V_FULL;
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        int p, t, lh;
        lh = tfpc_pkg::LinkHeaderBytes;
        p = pos;
        t = lh + ip_hdr_len;
        if (status == tfpc_pkg::V_TRUNC) begin
            if (p == lh) begin
                ip_hdr_len = {b[3:0], 2'b00};
                if (ip_hdr_len < 20) status = tfpc_pkg::V_IP_SHORT;
            end else if (p == lh + 2 || p == lh + 3) begin
                ip_total = {ip_total[7:0], b};
            end else if (p == lh + 9) begin
                if (b != tfpc_pkg::ProtoTcp) status = tfpc_pkg::V_NOT_TCP;
            end else if (p >= lh + 12 && p < lh + 20) begin
                cur_addrs = {cur_addrs[55:0], b};
            end
            if (status == tfpc_pkg::V_TRUNC && p > lh && p >= t) begin
                if (p < t + 4) begin
                    cur_ports = {cur_ports[23:0], b};
                    if (p == t + 3 && cur_ports[15:0] != cap_port) status = tfpc_pkg::V_PORT;
                end else if (p < t + 12) begin
                    cur_seq_ack = {cur_seq_ack[55:0], b};
                end else if (p == t + 12) begin
                    tcp_hdr_len = {b[7:4], 2'b00};
                end
                if (status == tfpc_pkg::V_TRUNC && p >= t + 12 && p == decision_at())
                    decide_capture();
            end
        end else if (status == tfpc_pkg::V_APPEND || status == tfpc_pkg::V_NEW) begin
            if (p > decision_at() && p < lh + int'(ip_total)
                    && tbl_len[cur_slot] < tfpc_pkg::PayloadBytes) begin
                tbl_bytes[cur_slot][tbl_len[cur_slot]] = b;
                tbl_len[cur_slot]++;
            end
        end
        if (pos != 16'hFFFF) pos++;
    endfunction

    // Works out the result word, if any, that one accepted word causes.
    function automatic void predict_word(bit is_read, logic [7:0] b, bit last,
                                         logic [2:0] rslot, logic [6:0] ridx);
        result_t r;
        r = '0;
        if (is_read) begin
            r.verdict = tfpc_pkg::V_READ;
            r.slot = rslot;
            if (rslot < tfpc_pkg::TableEntries && tbl_valid[rslot]) begin
                r.length = tbl_len[rslot];
                r.count = tbl_count[rslot];
                if (ridx < tbl_len[rslot]) begin
                    r.rdata = tbl_bytes[rslot][ridx];
                    r.hit = 1'b1;
                end
            end
            pending_results.push_back(r);
            return;
        end
        parse_byte(b);
        if (!last) return;
        r.verdict = status;
        if (status == tfpc_pkg::V_APPEND || status == tfpc_pkg::V_NEW) begin
            r.slot = cur_slot;
            r.length = tbl_len[cur_slot];
            r.count = tbl_count[cur_slot];
        end
        pending_results.push_back(r);
        clear_frame();
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Each accepted result word is compared with the oldest expectation.
    initial begin
        result_t got, want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata[38:0];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result word %h", $realtime, m_tdata);
                    failed = 1'b1;
                end else begin
                    want = pending_results.pop_front();
                    if (got.verdict !== want.verdict || got.slot !== want.slot
                            || got.length !== want.length || got.count !== want.count
                            || got.rdata !== want.rdata || got.hit !== want.hit) begin
                        $display("%0t: expected verdict %0d slot %0d len %0d cnt %0d %h %0b",
                                 $realtime, want.verdict, want.slot, want.length,
                                 want.count, want.rdata, want.hit);
                        $display("%0t: actual   verdict %0d slot %0d len %0d cnt %0d %h %0b",
                                 $realtime, got.verdict, got.slot, got.length,
                                 got.count, got.rdata, got.hit);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic send_word(bit is_read, logic [7:0] b, bit last,
                             logic [2:0] rslot, logic [6:0] ridx);
        @(negedge aclk);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_read;
        s_tlast  <= last;
        s_tdata  <= {6'd0, ridx, rslot, b};
        predict_word(is_read, b, last, rslot, ridx);
        words_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_read(logic [2:0] rslot, logic [6:0] ridx);
        send_word(1'b1, 8'($urandom), 1'($urandom), rslot, ridx);
    endtask

    task automatic send_random_read();
        send_read(3'($urandom), 7'($urandom));
    endtask

    // Sends the bytes in frame_bytes, with reads mixed in between.
    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            if ($urandom_range(99) < read_mix_pct) send_random_read();
            send_word(1'b0, frame_bytes[i], i == frame_bytes.size() - 1,
                      3'($urandom), 7'($urandom));
        end
    endtask

    // Builds one frame. A negative cut keeps the whole frame.
    function automatic void build_frame(int flow, int ihl, logic [7:0] proto,
                                        logic [15:0] dport, int doff, int plen,
                                        int total_adj, int cut, int pad);
        int total;
        logic [7:0] opt;
        flow_key_t k;
        k = flows[flow];
        total = ihl * 4 + doff * 4 + plen + total_adj;
        if (total < 0) total = 0;
        if (total > 65535) total = 65535;
        frame_bytes.delete();
        repeat (tfpc_pkg::LinkHeaderBytes) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back({4'd4, 4'(ihl)});
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'(total >> 8));
        frame_bytes.push_back(8'(total));
        repeat (5) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(proto);
        repeat (2) frame_bytes.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--) frame_bytes.push_back(k.src[i*8 +: 8]);
        for (int i = 3; i >= 0; i--) frame_bytes.push_back(k.dst[i*8 +: 8]);
        repeat ((ihl > 5) ? ihl * 4 - 20 : 0) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(k.sport[15:8]);
        frame_bytes.push_back(k.sport[7:0]);
        frame_bytes.push_back(dport[15:8]);
        frame_bytes.push_back(dport[7:0]);
        for (int i = 3; i >= 0; i--) frame_bytes.push_back(k.seq[i*8 +: 8]);
        for (int i = 3; i >= 0; i--) frame_bytes.push_back(k.ack[i*8 +: 8]);
        opt = 8'($urandom);
        frame_bytes.push_back({4'(doff), opt[3:0]});
        repeat (7) frame_bytes.push_back(8'($urandom));
        repeat ((doff > 5) ? doff * 4 - 20 : 0) frame_bytes.push_back(8'($urandom));
        repeat (plen + pad) frame_bytes.push_back(8'($urandom));
        if (cut > 0) while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    endfunction

    task automatic good_frame(int flow, int plen);
        build_frame(flow, 5, tfpc_pkg::ProtoTcp, cap_port, 5, plen, 0, -1, 0);
        send_frame();
    endtask

    // Random frame: mostly well formed, the rest broken in one way.
    task automatic random_frame();
        int ihl, doff, plen, adj, cut, pad, sel;
        logic [7:0] proto;
        logic [15:0] dport;
        ihl = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : 5;
        doff = ($urandom_range(9) == 0) ? $urandom_range(2, 9) : 5;
        plen = ($urandom_range(19) == 0) ? $urandom_range(40, 130) : $urandom_range(0, 30);
        proto = tfpc_pkg::ProtoTcp;
        dport = cap_port;
        adj = 0;
        cut = -1;
        pad = ($urandom_range(4) == 0) ? $urandom_range(1, 8) : 0;
        sel = $urandom_range(99);
        if (sel < 5) ihl = $urandom_range(0, 4);
        else if (sel < 10) proto = 8'($urandom);
        else if (sel < 15) dport = 16'($urandom);
        else if (sel < 20) adj = -$urandom_range(1, 60);
        else if (sel < 27) cut = $urandom_range(1, 70);
        else if (sel < 30) doff = $urandom_range(0, 15);
        build_frame($urandom_range(7), ihl, proto, dport, doff, plen, adj, cut, pad);
        send_frame();
    endtask

    // Lowers valid and waits until every expected result has come.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        if (idx == tfpc_pkg::RegMatchPort) cap_port = value;
        else cap_min_payload = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [7:0] tcp;
        tcp = tfpc_pkg::ProtoTcp;
        good_frame(0, 20);                                   // new entry
        good_frame(0, 90);                                   // append, capped at 100
        send_read(0, 0);
        send_read(0, 99);
        send_read(0, 100);
        send_read(0, 127);
        send_read(4, 0);                                     // invalid entry
        send_read(7, 5);                                     // no such entry
        build_frame(1, 4, tcp, cap_port, 5, 20, 0, -1, 0);   send_frame();
        build_frame(1, 5, 8'd17, cap_port, 5, 20, 0, -1, 0); send_frame();
        build_frame(1, 5, tcp, ~cap_port, 5, 20, 0, -1, 0);  send_frame();
        good_frame(1, 10);                                   // payload equals minimum
        build_frame(1, 5, tcp, cap_port, 5, 20, -50, -1, 0); send_frame();
        build_frame(1, 5, tcp, cap_port, 5, 20, 0, 30, 0);   send_frame();
        build_frame(2, 5, tcp, cap_port, 2, 30, 0, -1, 0);   send_frame();
        build_frame(3, 7, tcp, cap_port, 8, 25, 0, 80, 0);   send_frame();
        build_frame(4, 5, tcp, cap_port, 5, 15, 0, -1, 30);  send_frame();
        send_read(2, 3);
        send_read(3, 0);
    endtask

    task automatic test_config();
        write_reg(tfpc_pkg::RegMatchPort, 16'd0);
        write_reg(tfpc_pkg::RegMinPayload, 16'd0);
        good_frame(5, 1);
        good_frame(6, 0);
        write_reg(tfpc_pkg::RegMatchPort, 16'hFFFF);
        write_reg(tfpc_pkg::RegMinPayload, 16'hFFFF);
        good_frame(5, 40);
        write_reg(tfpc_pkg::RegMinPayload, 16'd5);
        good_frame(5, 12);
        write_reg(tfpc_pkg::RegMatchPort, tfpc_pkg::MatchPortReset);
        write_reg(tfpc_pkg::RegMinPayload, tfpc_pkg::MinPayloadReset);
    endtask

    task automatic test_random(int stall, int gap, int words);
        int stop_at;
        stall_pct = stall;
        gap_pct = gap;
        stop_at = words_sent + words;
        while (words_sent < stop_at) begin
            random_frame();
            if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) send_random_read();
        end
    endtask

    // Long receiver hold-off while reads keep arriving back to back.
    task automatic test_backpressure();
        stall_pct = 0;
        gap_pct = 0;
        hold_req = 60;
        repeat (30) send_random_read();
        good_frame(0, 15);
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; s_tuser = 1'b0;
        m_tready = 1'b0; cfg_wr_en = 1'b0; cfg_addr = 1'b0; cfg_data = '0;
        stall_pct = 0; gap_pct = 0; read_mix_pct = 8; hold_req = 0;
        words_sent = 0; failed = 1'b0;
        cap_port = tfpc_pkg::MatchPortReset;
        cap_min_payload = tfpc_pkg::MinPayloadReset;
        clear_frame();
        for (int i = 0; i < tfpc_pkg::TableEntries; i++) begin
            tbl_valid[i] = 1'b0; tbl_len[i] = 0; tbl_count[i] = 0;
        end
        for (int i = 0; i < 8; i++) begin
            flows[i].src = $urandom; flows[i].dst = $urandom;
            flows[i].seq = $urandom; flows[i].ack = $urandom;
            flows[i].sport = 16'($urandom);
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_config();
        test_backpressure();
        test_random(0, 79, 80);
        wait_drained();
        test_random(79, 0, 80);
        test_random(35, 35, 80);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        stall_pct = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (!failed) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
